// ===== src/acwg_pkg.sv =====
// Shared types, constants and waveform tables for the audio channel waveform generator.
`timescale 1ns / 1ps

package acwg_pkg;

    localparam int PERIOD_W   = 16;
    localparam int DIV_W      = 17;
    localparam int STEP_W     = 5;
    localparam int NOISE_W    = 15;
    localparam int LEVEL_W    = 4;
    localparam int KIND_W     = 2;
    localparam int DUTY_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // channel kinds
    localparam logic [KIND_W-1:0] KIND_SQUARE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOISE    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 16'h0fff;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN_OFF = 16'd8;

    localparam logic [KIND_W-1:0]   RST_KIND     = KIND_SQUARE;
    localparam logic [PERIOD_W-1:0] RST_PERIOD   = 16'h0fff;
    localparam logic [PERIOD_W-1:0] RST_PITCH    = 16'h0000;
    localparam logic [LEVEL_W-1:0]  RST_VOLUME   = 4'hf;
    localparam logic [DUTY_W-1:0]   RST_DUTY     = 2'd0;
    localparam logic [DIV_W-1:0]    RST_INTERVAL = 17'h00fff;
    localparam logic [NOISE_W-1:0]  RST_NOISE    = 15'h0001;

    localparam logic [LEVEL_W-1:0]  TRI_MUTE_LEVEL = 4'd8;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [PERIOD_W-1:0]        period;
        logic signed [PERIOD_W-1:0] pitch;
        logic [LEVEL_W-1:0]         volume;
        logic [DUTY_W-1:0]          duty;
    } t_cfg;

    // divider reload request from a period write
    typedef struct packed {
        logic             reload;
        logic [DIV_W-1:0] interval;
    } t_cfg_ctl;

    function automatic logic chan_enabled(input logic [PERIOD_W-1:0] period);
        return (period <= PERIOD_MAX) && (period > PERIOD_MIN_OFF);
    endfunction

    // period + signed pitch, clamped to at least 1
    function automatic logic [DIV_W-1:0] eff_interval(
        input logic [PERIOD_W-1:0]        period,
        input logic signed [PERIOD_W-1:0] pitch
    );
        logic signed [DIV_W:0] sum;
        sum = $signed({2'b00, period}) + $signed({{2{pitch[PERIOD_W-1]}}, pitch});
        if (sum[DIV_W] || (sum == '0)) begin
            return DIV_W'(1);
        end
        return sum[DIV_W-1:0];
    endfunction

    function automatic logic duty_bit(input logic [DUTY_W-1:0] duty, input logic [2:0] idx);
        logic [7:0] pat;
        case (duty)
            2'd0:    pat = 8'b0000_0010;
            2'd1:    pat = 8'b0000_0110;
            2'd2:    pat = 8'b0001_1110;
            2'd3:    pat = 8'b1111_1001;
            default: pat = 8'b0000_0000;
        endcase
        return pat[idx];
    endfunction

    // 15..0 then 0..15
    function automatic logic [LEVEL_W-1:0] ramp_level(input logic [STEP_W-1:0] idx);
        if (idx[STEP_W-1]) begin
            return idx[LEVEL_W-1:0];
        end
        return ~idx[LEVEL_W-1:0];
    endfunction

endpackage

// ===== src/acwg_cfg.sv =====
// Configuration register file with divider reload on period writes.
`timescale 1ns / 1ps

module acwg_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [acwg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [acwg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output acwg_pkg::t_cfg                    o_cfg,
    output acwg_pkg::t_cfg_ctl                o_ctl
);

    acwg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind   <= acwg_pkg::RST_KIND;
            r_cfg.period <= acwg_pkg::RST_PERIOD;
            r_cfg.pitch  <= acwg_pkg::RST_PITCH;
            r_cfg.volume <= acwg_pkg::RST_VOLUME;
            r_cfg.duty   <= acwg_pkg::RST_DUTY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acwg_pkg::REG_KIND:   r_cfg.kind   <= i_cfg_data[acwg_pkg::KIND_W-1:0];
                acwg_pkg::REG_PERIOD: r_cfg.period <= i_cfg_data;
                acwg_pkg::REG_PITCH:  r_cfg.pitch  <= i_cfg_data;
                acwg_pkg::REG_VOLUME: r_cfg.volume <= i_cfg_data[acwg_pkg::LEVEL_W-1:0];
                acwg_pkg::REG_DUTY:   r_cfg.duty   <= i_cfg_data[acwg_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // new period reloads the divider at once, only if the new period enables the channel
    always_comb begin
        o_ctl.reload   = i_cfg_we && (i_cfg_idx == acwg_pkg::REG_PERIOD)
                         && acwg_pkg::chan_enabled(i_cfg_data);
        o_ctl.interval = acwg_pkg::eff_interval(i_cfg_data, r_cfg.pitch);
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/acwg_core.sv =====
// Divider and waveform state: next state and output level for one item.
`timescale 1ns / 1ps

module acwg_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  acwg_pkg::t_cfg                 i_cfg,
    input  acwg_pkg::t_cfg_ctl             i_ctl,
    input  logic                           i_advance,
    output logic [acwg_pkg::LEVEL_W-1:0]   o_level,
    output logic                           o_stepped,
    output logic                           o_on
);

    logic [acwg_pkg::DIV_W-1:0]   r_div,   n_div;
    logic [acwg_pkg::STEP_W-1:0]  r_step,  n_step;
    logic [acwg_pkg::NOISE_W-1:0] r_noise, n_noise;
    logic [acwg_pkg::LEVEL_W-1:0] r_held,  n_held;

    logic on;
    logic expire;
    logic fb;

    assign on     = acwg_pkg::chan_enabled(i_cfg.period);
    assign expire = i_advance && on && (r_div <= acwg_pkg::DIV_W'(1));
    assign fb     = r_noise[0] ^ ((i_cfg.duty != '0) ? r_noise[6] : r_noise[1]);

    always_comb begin
        n_div   = r_div;
        n_step  = r_step;
        n_noise = r_noise;
        n_held  = r_held;
        if (i_ctl.reload) begin
            n_div = i_ctl.interval;
        end else if (i_advance && on) begin
            if (expire) begin
                n_div = acwg_pkg::eff_interval(i_cfg.period, i_cfg.pitch);
                case (i_cfg.kind)
                    acwg_pkg::KIND_SQUARE: begin
                        n_held = acwg_pkg::duty_bit(i_cfg.duty, r_step[2:0]) ? i_cfg.volume
                                                                             : '0;
                        n_step = {2'b00, r_step[2:0] + 3'd1};
                    end
                    acwg_pkg::KIND_TRIANGLE: begin
                        n_held = (i_cfg.volume != '0) ? acwg_pkg::ramp_level(r_step)
                                                      : acwg_pkg::TRI_MUTE_LEVEL;
                        n_step = r_step + acwg_pkg::STEP_W'(1);
                    end
                    acwg_pkg::KIND_NOISE: begin
                        n_step  = {{(acwg_pkg::STEP_W-1){1'b0}}, fb};
                        n_noise = {fb, r_noise[acwg_pkg::NOISE_W-1:1]};
                        n_held  = fb ? {1'b0, i_cfg.volume[acwg_pkg::LEVEL_W-1:1]} : '0;
                    end
                    default: ;
                endcase
            end else begin
                n_div = r_div - acwg_pkg::DIV_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= acwg_pkg::RST_INTERVAL;
            r_step  <= '0;
            r_noise <= acwg_pkg::RST_NOISE;
            r_held  <= '0;
        end else begin
            r_div   <= n_div;
            r_step  <= n_step;
            r_noise <= n_noise;
            r_held  <= n_held;
        end
    end

    assign o_level   = n_held;
    assign o_stepped = expire;
    assign o_on      = on;

endmodule

// ===== src/apu_channel_waveform_generator.sv =====
// Top level: one audio channel (square, triangle, noise) with stream handshake.
`timescale 1ns / 1ps
// An accepted item's result is registered and shows on m_axis in the next cycle.
// Throughput: one item per cycle while m_axis_tready is high; the single result register
//   lets a new item enter in the same cycle the pending result is taken.
// Reset (i_rst_n low, synchronous): registers to defaults (square, period 4095,
//   volume 15), divider loaded with 4095, noise register 1, output empty.

module apu_channel_waveform_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [acwg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [acwg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] cycle_elapsed
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata   // [3:0] sample_level,
                                                             // [4] stepped, [5] channel_on
);

    acwg_pkg::t_cfg     cfg;
    acwg_pkg::t_cfg_ctl ctl;

    logic                         accept;
    logic [acwg_pkg::LEVEL_W-1:0] level;
    logic                         stepped;
    logic                         on;

    logic       r_out_valid;
    logic [7:0] r_out_data;

    // take a new item whenever the result register is empty or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    acwg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_ctl      (ctl)
    );

    // state only moves on an accepted item with a cycle elapsed, or by a divider reload on a period write
    acwg_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_ctl     (ctl),
        .i_advance (accept && s_axis_tdata[0]),
        .o_level   (level),
        .o_stepped (stepped),
        .o_on      (on)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {2'b00, on, stepped, level};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== src/acwg_checker.sv =====
// Port-level checks for the channel waveform generator, bound to the top level.
`timescale 1ns / 1ps

module acwg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // empty output register never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("ready low with empty output");

    // every item yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // a sample-only item never steps
    a_sample_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready && !s_axis_tdata[0]) |=>
            !m_axis_tdata[4])
        else $error("sample-only item stepped");

    // stepping needs the channel on
    a_step_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[5])
        else $error("step with channel off");

endmodule

bind apu_channel_waveform_generator acwg_checker u_acwg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the audio channel waveform generator.
`timescale 1ns / 1ps

// Tests one audio channel (square, triangle, noise and the unused kind) over its stream ports.
// A scoreboard class keeps its own model of the divider, step index, noise register and
// held level, and predicts one result for each accepted item. Registers change only while the
// channel is drained. A short directed part covers the period limits, interval saturation,
// the muted triangle, both noise taps and ignored register indexes. Random phases follow, each
// with fresh settings and mostly short intervals so that the waveforms step often. Both stream
// sides idle at random.

module testbench;
    import acwg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int REPORT_MAX   = 10;

    // result fields as packed in m_axis_tdata[5:0]
    typedef struct packed {
        logic               on;
        logic               stepped;
        logic [LEVEL_W-1:0] level;
    } chan_out_t;

    class sample_scoreboard;
        // register copies
        logic [KIND_W-1:0]          kind_r;
        logic [PERIOD_W-1:0]        period_r;
        logic signed [PERIOD_W-1:0] pitch_r;
        logic [LEVEL_W-1:0]         volume_r;
        logic [DUTY_W-1:0]          duty_r;
        // channel state
        logic [DIV_W-1:0]   divider;
        logic [STEP_W-1:0]  wave_pos;
        logic [NOISE_W-1:0] lfsr;
        logic [LEVEL_W-1:0] level;
        bit [7:0]           duty_pat [4];

        chan_out_t expected_samples[$];
        int        mismatches;
        int        checked;

        function new();
            kind_r      = KIND_SQUARE;
            period_r    = 16'h0fff;
            pitch_r     = '0;
            volume_r    = 4'hf;
            duty_r      = '0;
            divider     = reload_value();
            wave_pos    = '0;
            lfsr        = 15'h0001;
            level       = '0;
            duty_pat    = '{8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001};
            mismatches  = 0;
            checked     = 0;
        endfunction

        function bit running();
            return period_r <= PERIOD_MAX && period_r > PERIOD_MIN_OFF;
        endfunction

        // period plus signed pitch, never below 1
        function logic [DIV_W-1:0] reload_value();
            int sum;
            sum = int'(period_r) + int'(pitch_r);
            if (sum < 1) begin
                sum = 1;
            end
            return DIV_W'(sum);
        endfunction

        function void step_wave();
            logic fb;
            case (kind_r)
                KIND_SQUARE: begin
                    // only the low three bits select the duty slot
                    level    = duty_pat[duty_r][wave_pos[2:0]] ? volume_r : 4'd0;
                    wave_pos = {2'b00, wave_pos[2:0] + 3'd1};
                end
                KIND_TRIANGLE: begin
                    if (volume_r == '0) begin
                        level = TRI_MUTE_LEVEL;
                    end else begin
                        level = wave_pos[4] ? wave_pos[3:0] : 4'd15 - wave_pos[3:0];
                    end
                    wave_pos = wave_pos + 5'd1;
                end
                KIND_NOISE: begin
                    fb       = lfsr[0] ^ ((duty_r != '0) ? lfsr[6] : lfsr[1]);
                    wave_pos = {4'd0, fb};
                    lfsr     = {fb, lfsr[NOISE_W-1:1]};
                    level    = fb ? (volume_r >> 1) : 4'd0;
                end
                default: begin
                end
            endcase
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_KIND:   kind_r = data[KIND_W-1:0];
                REG_PERIOD: begin
                    period_r = data;
                    if (running()) begin
                        divider = reload_value();
                    end
                end
                REG_PITCH:  pitch_r = data;
                REG_VOLUME: volume_r = data[LEVEL_W-1:0];
                REG_DUTY:   duty_r = data[DUTY_W-1:0];
                default: begin
                end
            endcase
        endfunction

        // one accepted item: advance the channel and queue the sample it yields
        function void cycle_item(logic elapsed);
            chan_out_t want;
            want.on      = running();
            want.stepped = 1'b0;
            if (elapsed && want.on) begin
                if (divider <= DIV_W'(1)) begin
                    step_wave();
                    divider      = reload_value();
                    want.stepped = 1'b1;
                end else begin
                    divider = divider - DIV_W'(1);
                end
            end
            want.level = level;
            expected_samples.push_back(want);
        endfunction

        function void report(string what, int want_v, int got_v);
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         checked, what, want_v, got_v);
            end
        endfunction

        function void check_result(logic [7:0] data);
            chan_out_t got;
            chan_out_t want;
            got = chan_out_t'(data[5:0]);
            if (expected_samples.size() == 0) begin
                report("result with nothing pending, tdata", 0, data);
                return;
            end
            want = expected_samples.pop_front();
            if (got.level !== want.level) begin
                report("sample_level", want.level, got.level);
            end
            if (got.stepped !== want.stepped) begin
                report("stepped", want.stepped, got.stepped);
            end
            if (got.on !== want.on) begin
                report("channel_on", want.on, got.on);
            end
            checked++;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [0] cycle_elapsed
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [3:0] sample_level, [4] stepped, [5] channel_on

    sample_scoreboard sb;
    int send_gap_pct   = 9;
    int sink_stall_pct = 74;
    int cycle_count    = 0;

    apu_channel_waveform_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side stalls at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // watch both streams and the register port; results are checked before the
    // item of the same edge is queued (it cannot be the one leaving)
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.cycle_item(s_axis_tdata[0]);
            end
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_idx, i_cfg_data);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // holds the write enable high; the caller drops it after the last write
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic elapsed);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, elapsed};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // n items, bit i of pattern gives cycle_elapsed of item i
    task automatic send_bits(input int n, input logic [31:0] pattern);
        for (int i = 0; i < n; i++) begin
            send_item(pattern[i]);
        end
    endtask

    // stop sending until every queued sample has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // narrow register value with random junk above it half the time
    function automatic logic [CFG_DATA_W-1:0] padded(input int value, input int width);
        logic [CFG_DATA_W-1:0] d;
        d = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom()) : '0;
        for (int b = 0; b < width; b++) begin
            d[b] = value[b];
        end
        return d;
    endfunction

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] period_v;
        logic [CFG_DATA_W-1:0] pitch_v;
        int                    pick;
        bit                    pitch_late;

        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            period_v = CFG_DATA_W'($urandom_range(9, 24));
        end else if (pick < 75) begin
            period_v = CFG_DATA_W'($urandom_range(25, 4095));
        end else if (pick < 85) begin
            period_v = ($urandom_range(0, 1) != 0) ? 16'd9 : 16'h0fff;
        end else if (pick < 92) begin
            period_v = CFG_DATA_W'($urandom_range(0, 8));
        end else begin
            period_v = CFG_DATA_W'($urandom_range(4096, 65535));
        end

        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            pitch_v = CFG_DATA_W'($urandom_range(0, 20) - 10);
        end else if (pick < 70) begin
            pitch_v = CFG_DATA_W'(-$urandom_range(20, 32768));
        end else if (pick < 80) begin
            pitch_v = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
        end else begin
            pitch_v = CFG_DATA_W'($urandom());
        end

        // a pitch written after the period waits for the next reload
        pitch_late = ($urandom_range(0, 3) == 0);

        if ($urandom_range(0, 4) != 0) begin
            reg_write(REG_KIND, padded(($urandom_range(0, 9) == 0) ? 3
                                       : $urandom_range(0, 2), KIND_W));
        end
        if ($urandom_range(0, 4) != 0) begin
            reg_write(REG_VOLUME, padded($urandom_range(0, 15), LEVEL_W));
        end
        if ($urandom_range(0, 4) != 0) begin
            reg_write(REG_DUTY, padded($urandom_range(0, 3), DUTY_W));
        end
        if (!pitch_late) begin
            reg_write(REG_PITCH, pitch_v);
        end
        if ($urandom_range(0, 4) != 0) begin
            reg_write(REG_PERIOD, period_v);
        end
        if (pitch_late) begin
            reg_write(REG_PITCH, pitch_v);
        end
        if ($urandom_range(0, 7) == 0) begin
            reg_write(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom()));
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int done;
        int phase_len;

        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // reset settings: square, period 4095, long divider, no step yet
        send_bits(3, 32'b101);

        // interval saturated to 1 by the most negative pitch: steps on every elapsed item
        settle();
        reg_write(REG_KIND, CFG_DATA_W'(KIND_SQUARE));
        reg_write(REG_DUTY, 16'd3);
        reg_write(REG_PITCH, 16'h8000);
        reg_write(REG_PERIOD, 16'd9);
        i_cfg_we <= 1'b0;
        send_bits(4, 32'b0111);

        // period limits: 8, 4096, all ones and zero all switch the channel off
        settle();
        reg_write(REG_PERIOD, 16'd8);
        i_cfg_we <= 1'b0;
        send_item(1'b1);
        settle();
        reg_write(REG_PERIOD, 16'd4096);
        i_cfg_we <= 1'b0;
        send_item(1'b1);
        settle();
        reg_write(REG_PERIOD, 16'hffff);
        i_cfg_we <= 1'b0;
        send_item(1'b1);
        settle();
        reg_write(REG_PERIOD, 16'd0);
        i_cfg_we <= 1'b0;
        send_item(1'b1);

        // triangle muted at volume zero, then the ramp at full volume
        settle();
        reg_write(REG_KIND, CFG_DATA_W'(KIND_TRIANGLE));
        reg_write(REG_VOLUME, 16'd0);
        reg_write(REG_PERIOD, 16'd9);
        i_cfg_we <= 1'b0;
        send_bits(2, 32'b11);
        settle();
        reg_write(REG_VOLUME, 16'hffff);
        i_cfg_we <= 1'b0;
        send_bits(2, 32'b11);

        // unused kind: divider steps but the level holds
        settle();
        reg_write(REG_KIND, 16'd3);
        i_cfg_we <= 1'b0;
        send_bits(2, 32'b11);

        // noise with the long tap, then the short tap
        settle();
        reg_write(REG_KIND, CFG_DATA_W'(KIND_NOISE));
        reg_write(REG_DUTY, 16'd0);
        i_cfg_we <= 1'b0;
        send_bits(2, 32'b11);
        settle();
        reg_write(REG_DUTY, 16'd2);
        i_cfg_we <= 1'b0;
        send_bits(2, 32'b11);

        // largest interval, then writes to indexes past the last register
        settle();
        reg_write(REG_PERIOD, 16'h0fff);
        reg_write(REG_PITCH, 16'h7fff);
        reg_write(3'd5, 16'hffff);
        reg_write(3'd6, 16'hffff);
        reg_write(3'd7, 16'hffff);
        i_cfg_we <= 1'b0;
        send_bits(2, 32'b01);

        // ---- random phases ----
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done < RANDOM_ITEMS / 3) begin
                send_gap_pct   = 9;
                sink_stall_pct = 74;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_gap_pct   = 74;
                sink_stall_pct = 9;
            end else begin
                send_gap_pct   = 0;
                sink_stall_pct = 0;
            end
            settle();
            random_setup();
            phase_len = $urandom_range(20, 90);
            for (int i = 0; i < phase_len; i++) begin
                send_item($urandom_range(0, 99) < 85);
                done++;
                // occasional drain in the middle of a phase
                if ($urandom_range(0, 299) == 0) begin
                    settle();
                end
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== apu_channel_waveform_generator.f =====
src/acwg_pkg.sv
src/acwg_cfg.sv
src/acwg_core.sv
src/apu_channel_waveform_generator.sv
src/acwg_checker.sv
tb/testbench.sv
